@@ rtl/core/afr_pkg.sv @@
package afr_pkg;

    localparam int unsigned HDR_LEN = 6;
    localparam int unsigned SUM_LEN = 5;
    localparam int unsigned LEN_POS = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [7:0] t_byte;
    typedef t_byte t_window [HDR_LEN];

    // One byte of reflected Modbus CRC-16, eight shift/xor steps.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/addressed_frame_receiver_crc16.sv @@
// Addressed frame receiver with Modbus CRC-16 check.
//
// Channels: the rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one
// received byte per beat. The out channel (o_out_valid / i_out_ready) carries
// one beat per payload byte: the byte, its index, the frame length, a last
// flag and, on the last beat, the CRC verdict. The cfg channel (i_cfg_valid /
// o_cfg_ready / i_cfg_data) writes the 16-bit local address; it is always
// ready. The user must write it only while the block is idle (not enforced).
//
// Header bytes shift through a six-byte window and give no beat. A header
// matches on address, 8-bit checksum and nonzero length. Each payload byte
// gives one beat in the cycle after it is accepted. One byte is taken every
// cycle unless the output stalls: the header check and the eight-step CRC
// update sit between the state registers and the output register.
//
// Reset clears the window, returns to hunting, presets the CRC and empties
// the output register. When the receiver stalls, the output beat holds and
// o_rx_ready drops until the beat is taken; ready is combinational from
// i_out_ready so no cycle is lost while it drains.
module addressed_frame_receiver_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_frame_length,
    output logic        o_is_last,
    output logic        o_frame_ok
);

    logic [15:0]      r_local_addr;
    afr_pkg::t_window r_win;
    afr_pkg::t_window n_win;
    logic             r_in_payload;
    logic             n_in_payload;
    logic [7:0]       r_count;
    logic [7:0]       n_count;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;

    logic             r_out_valid;
    logic [7:0]       r_payload_byte;
    logic [7:0]       r_byte_index;
    logic [7:0]       r_frame_length;
    logic             r_is_last;
    logic             r_frame_ok;

    logic             rx_acc;
    logic             emit;
    logic [7:0]       hdr_sum;
    logic             hdr_match;
    logic [15:0]      crc_next;
    logic [8:0]       count_inc;
    logic             last;
    logic             ok;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_out_valid || i_out_ready;
    assign rx_acc      = i_rx_valid && o_rx_ready;
    assign emit        = rx_acc && r_in_payload;

    // Header check on the window as it stands after this byte shifts in.
    always_comb begin
        hdr_sum = 8'h00;
        for (int i = 1; i < int'(afr_pkg::HDR_LEN); i++) begin
            hdr_sum = hdr_sum + r_win[i];
        end
        hdr_match = (r_win[1] == r_local_addr[15:8]) &&
                    (r_win[2] == r_local_addr[7:0]) &&
                    (hdr_sum == i_rx_byte) &&
                    (r_win[afr_pkg::LEN_POS + 1] != 8'h00);
    end

    // Payload path: CRC update, last-byte and verdict.
    always_comb begin
        crc_next  = afr_pkg::crc16_update(r_crc, i_rx_byte);
        count_inc = {1'b0, r_count} + 9'd1;
        last      = count_inc >= {1'b0, r_win[afr_pkg::LEN_POS]};
        ok        = last && (crc_next == {r_win[2], r_win[3]});
    end

    always_comb begin
        n_win        = r_win;
        n_in_payload = r_in_payload;
        n_count      = r_count;
        n_crc        = r_crc;
        if (rx_acc) begin
            if (!r_in_payload) begin
                // shift the byte into the window
                for (int i = 0; i < int'(afr_pkg::HDR_LEN) - 1; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[afr_pkg::HDR_LEN - 1] = i_rx_byte;
                if (hdr_match) begin
                    n_in_payload = 1'b1;
                    n_count      = 8'h00;
                    n_crc        = afr_pkg::CRC_INIT;
                end
            end else if (last) begin
                // end of frame: drop the header, back to hunting
                for (int i = 0; i < int'(afr_pkg::HDR_LEN); i++) begin
                    n_win[i] = 8'h00;
                end
                n_in_payload = 1'b0;
                n_count      = 8'h00;
                n_crc        = afr_pkg::CRC_INIT;
            end else begin
                n_count = count_inc[7:0];
                n_crc   = crc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= 16'h0000;
            for (int i = 0; i < int'(afr_pkg::HDR_LEN); i++) begin
                r_win[i] <= 8'h00;
            end
            r_in_payload <= 1'b0;
            r_count      <= 8'h00;
            r_crc        <= afr_pkg::CRC_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_local_addr <= i_cfg_data;
            end
            r_win        <= n_win;
            r_in_payload <= n_in_payload;
            r_count      <= n_count;
            r_crc        <= n_crc;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_payload_byte <= i_rx_byte;
            r_byte_index   <= r_count;
            r_frame_length <= r_win[afr_pkg::LEN_POS];
            r_is_last      <= last;
            r_frame_ok     <= ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_byte_index   = r_byte_index;
    assign o_frame_length = r_frame_length;
    assign o_is_last      = r_is_last;
    assign o_frame_ok     = r_frame_ok;

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_win[afr_pkg::LEN_POS] != 8'h00)
        else $error("in payload with zero frame length");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_index < o_frame_length)
        else $error("byte index beyond frame length");

    a_ok_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_is_last)
        else $error("frame_ok on a non-final byte");

    a_last_returns_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && last |=> !r_in_payload && o_out_valid && o_is_last)
        else $error("last byte did not return to hunting");

endmodule
